FILE: hw/rtl/mrr_pkg.sv
// ----------------------------------------------------------------------------
// mrr_pkg: shared constants and types for the Miller-Rabin round block
// Holds the default operand width and the sequencer state encoding.
// ----------------------------------------------------------------------------
package mrr_pkg;

  localparam int unsigned NumberBitsDef = 32;
  localparam int unsigned RandomBits    = 31;

  typedef enum logic [3:0] {
    StIdle,
    StRed,
    StRedRun,
    StFindD,
    StPowSq,
    StPowMul,
    StMulRun,
    StCheck,
    StLoopSq,
    StLoopChk,
    StDone
  } mrr_state_e;

endpackage

FILE: hw/rtl/mrr_modmul.sv
// ----------------------------------------------------------------------------
// mrr_modmul: bit-serial modular multiplier
// Computes (a * b) mod n one multiplier bit per cycle, MSB first, with the
// running sum kept below n by two conditional subtractions per step.
// ----------------------------------------------------------------------------
module mrr_modmul #(
  parameter int unsigned W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic [W-1:0] n_i,
  output logic         done_o,
  output logic [W-1:0] p_o
);
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  acc_q, acc_d;
  logic [W-1:0]  b_q, b_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          run_q, run_d;
  logic          done_q, done_d;
  logic [W+1:0]  s0, s1, s2;

  always_comb begin
    s0 = {1'b0, acc_q, 1'b0};
    if (s0 >= {2'b0, n_i}) s0 = s0 - {2'b0, n_i};
    s1 = s0 + (b_q[W-1] ? {2'b0, a_i} : '0);
    s2 = s1;
    if (s2 >= {2'b0, n_i}) s2 = s2 - {2'b0, n_i};
  end

  always_comb begin
    acc_d  = acc_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d = '0;
      b_d   = b_i;
      cnt_d = CW'(W);
      run_d = 1'b1;
    end else if (run_q) begin
      acc_d = s2[W-1:0];
      b_d   = {b_q[W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    b_q   <= b_d;
  end

  assign done_o = done_q;
  assign p_o    = acc_q;
endmodule

FILE: hw/rtl/mrr_modred.sv
// ----------------------------------------------------------------------------
// mrr_modred: bit-serial remainder
// Computes r mod m by restoring division, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module mrr_modred #(
  parameter int unsigned W  = 32,
  parameter int unsigned RW = 31
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [RW-1:0] r_i,
  input  logic [W-1:0]  m_i,
  output logic          done_o,
  output logic [W-1:0]  rem_o
);
  localparam int unsigned CW = $clog2(RW + 1);

  logic [W-1:0]  rem_q, rem_d;
  logic [RW-1:0] r_q, r_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          run_q, run_d;
  logic          done_q, done_d;
  logic [W:0]    t;

  always_comb begin
    t = {rem_q, r_q[RW-1]};
    if (t >= {1'b0, m_i}) t = t - {1'b0, m_i};
  end

  always_comb begin
    rem_d  = rem_q;
    r_d    = r_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = '0;
      r_d   = r_i;
      cnt_d = CW'(RW);
      run_d = 1'b1;
    end else if (run_q) begin
      rem_d = t[W-1:0];
      r_d   = {r_q[RW-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    r_q   <= r_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;
endmodule

FILE: hw/rtl/miller_rabin_round_top.sv
// ----------------------------------------------------------------------------
// miller_rabin_round_top: one Miller-Rabin round on a 32-bit candidate
// Sequencer around a bit-serial modular multiplier and a serial remainder unit.
// ----------------------------------------------------------------------------
// Usage: drive candidate_i and random_value_i and pulse start_i while busy_o
// is low; the request is taken at that edge and busy_o rises the next cycle.
// When the round ends, done_o is high for exactly one cycle with
// probable_prime_o valid, and busy_o falls in the same cycle so a new request
// can be issued right away. The receiver cannot stall the block.
// Sequence: trivial candidates (0 to 4 and even numbers) are settled in StRed
// and go straight to StDone. Odd candidates run the witness reduction, then
// StFindD strips one trailing zero of n-1 per step before the modular
// exponentiation starts. With W as NUMBER_BITS, square-and-multiply uses up
// to 2W products and the squaring loop up to s-1 more, all of them on the
// single shared serial multiplier.
// One request is in flight at a time. Reset returns the sequencer to idle
// and drops busy_o and done_o; no result is pending after reset.
// ----------------------------------------------------------------------------
module miller_rabin_round_top #(
  parameter int unsigned NUMBER_BITS = mrr_pkg::NumberBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [NUMBER_BITS-1:0]       candidate_i,
  input  logic [mrr_pkg::RandomBits-1:0] random_value_i,
  output logic                         done_o,
  output logic                         probable_prime_o
);
  import mrr_pkg::*;

  localparam int unsigned W  = NUMBER_BITS;
  localparam int unsigned IW = $clog2(W);

  mrr_state_e st_q, st_d;
  logic [W-1:0]  n_q, n_d, d_q, d_d, x_q, x_d, a_q, a_d;
  logic [RandomBits-1:0] r_q, r_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [IW-1:0] s_q, s_d;
  logic          res_q, res_d;
  logic          done_q, done_d;

  logic          mul_start, mul_done, red_start, red_done;
  logic [W-1:0]  mul_a, mul_b, mul_p, red_rem, nm1;
  logic          pow_mul_pend_q, pow_mul_pend_d;

  assign nm1 = n_q - W'(1);

  mrr_modmul #(.W(W)) u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .n_i(n_q), .done_o(mul_done), .p_o(mul_p)
  );

  mrr_modred #(.W(W), .RW(RandomBits)) u_red (
    .clk_i, .rst_ni, .start_i(red_start), .r_i(r_q), .m_i(n_q - W'(4)),
    .done_o(red_done), .rem_o(red_rem)
  );

  // Exponent bits are scanned from the top: x = x^2, then x = x*a if bit set.
  always_comb begin
    st_d = st_q; n_d = n_q; d_d = d_q; x_d = x_q; a_d = a_q; r_d = r_q;
    idx_d = idx_q; s_d = s_q; res_d = res_q; done_d = 1'b0;
    pow_mul_pend_d = pow_mul_pend_q;
    mul_start = 1'b0; red_start = 1'b0;
    mul_a = x_q; mul_b = x_q;
    unique case (st_q)
      StIdle: begin
        if (start_i) begin
          n_d = candidate_i; r_d = random_value_i;
          st_d = StRed;
        end
      end
      StRed: begin
        if (n_q == W'(0) || n_q == W'(1) || n_q == W'(4)) begin
          res_d = 1'b0; st_d = StDone;
        end else if (n_q == W'(2) || n_q == W'(3)) begin
          res_d = 1'b1; st_d = StDone;
        end else if (!n_q[0]) begin
          res_d = 1'b0; st_d = StDone;
        end else begin
          red_start = 1'b1; d_d = nm1; s_d = '0; st_d = StRedRun;
        end
      end
      StRedRun: begin
        if (red_done) begin
          a_d = red_rem + W'(2);
          st_d = StFindD;
        end
      end
      StFindD: begin
        if (!d_q[0]) begin
          d_d = {1'b0, d_q[W-1:1]}; s_d = s_q + 1'b1;
        end else begin
          x_d = W'(1); idx_d = IW'(W - 1); st_d = StPowSq;
        end
      end
      StPowSq: begin
        mul_start = 1'b1; pow_mul_pend_d = 1'b0; st_d = StMulRun;
      end
      StPowMul: begin
        mul_a = x_q; mul_b = a_q; mul_start = 1'b1;
        pow_mul_pend_d = 1'b1; st_d = StMulRun;
      end
      StMulRun: begin
        mul_a = pow_mul_pend_q ? x_q : x_q;
        mul_b = pow_mul_pend_q ? a_q : x_q;
        if (mul_done) begin
          x_d = mul_p;
          if (!pow_mul_pend_q && d_q[idx_q]) begin
            st_d = StPowMul;
          end else if (idx_q == '0) begin
            st_d = StCheck;
          end else begin
            idx_d = idx_q - 1'b1; st_d = StPowSq;
          end
        end
      end
      StCheck: begin
        if (x_q == W'(1) || x_q == nm1) begin
          res_d = 1'b1; st_d = StDone;
        end else if (s_q <= IW'(1)) begin
          res_d = 1'b0; st_d = StDone;
        end else begin
          s_d = s_q - 1'b1; mul_start = 1'b1; st_d = StLoopSq;
        end
      end
      StLoopSq: begin
        if (mul_done) begin
          x_d = mul_p; st_d = StLoopChk;
        end
      end
      StLoopChk: begin
        if (x_q == W'(1)) begin
          res_d = 1'b0; st_d = StDone;
        end else if (x_q == nm1) begin
          res_d = 1'b1; st_d = StDone;
        end else if (s_q <= IW'(1)) begin
          res_d = 1'b0; st_d = StDone;
        end else begin
          s_d = s_q - 1'b1; mul_start = 1'b1; st_d = StLoopSq;
        end
      end
      StDone: begin
        done_d = 1'b1; st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      done_q <= 1'b0;
    end else begin
      st_q <= st_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; d_q <= d_d; x_q <= x_d; a_q <= a_d; r_q <= r_d;
    idx_q <= idx_d; s_q <= s_d; res_q <= res_d;
    pow_mul_pend_q <= pow_mul_pend_d;
  end

  assign busy_o           = (st_q != StIdle);
  assign done_o           = done_q;
  assign probable_prime_o = res_q;

  // A result strobe always follows the final state.
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StDone) |=> done_o) else $error("missing result strobe");
  // The block is idle in the cycle that carries a result.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result while busy");
  // The multiplier is never restarted while it finishes a product.
  a_mul_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |-> !mul_done) else $error("multiplier overlap");
endmodule
